[hdl/ole_pkg.sv]
// Shared types and constants for the ordered list engine.
// Used by the cell, the controller, the top level and the checker; no dependencies.
package ole_pkg;

	// Width of one stored value and default list depth.
	localparam int VALUE_W          = 32;
	localparam int DEFAULT_CAPACITY = 64;

	// Request codes carried in the op field of an input item.
	typedef enum logic [2:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_BACK  = 3'd1,
		OP_INS_AT    = 3'd2,
		OP_RM_FRONT  = 3'd3,
		OP_RM_BACK   = 3'd4,
		OP_RM_AT     = 3'd5,
		OP_SEARCH    = 3'd6,
		OP_CLEAR     = 3'd7
	} op_code_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_IGNORED = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// What every cell does at a clock edge.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_ROTATE
	} cell_op_t;

	// Command broadcast to the whole row of cells.
	typedef struct packed {
		cell_op_t            kind;
		logic [VALUE_W-1:0]  value;
	} cell_cmd_t;

	// Controller states.
	typedef enum logic {
		FSM_IDLE,
		FSM_SEARCH
	} fsm_state_t;

endpackage

[hdl/ole_cell.sv]
// One storage cell of the list: holds one value and trades it with its neighbors.
// Depends on ole_pkg for the command struct.
module ole_cell import ole_pkg::*; #(
	parameter int AW  = 7,
	parameter int IDX = 0
) (
	input  logic               clk,
	input  cell_cmd_t          cmd,
	input  logic [AW-1:0]      pos,
	input  logic [VALUE_W-1:0] left_data,
	input  logic [VALUE_W-1:0] right_data,
	output logic [VALUE_W-1:0] data
);

	localparam logic [AW-1:0] MY_IDX = AW'(IDX);

	logic [VALUE_W-1:0] data_q;
	logic [VALUE_W-1:0] data_next;

	// Insert opens a gap at pos by shifting up; remove closes one by shifting down;
	// rotate moves every value one place toward the head.
	always_comb begin
		data_next = data_q;
		unique case (cmd.kind)
			CELL_HOLD: data_next = data_q;
			CELL_INSERT: begin
				if (MY_IDX > pos) begin
					data_next = left_data;
				end else if (MY_IDX == pos) begin
					data_next = cmd.value;
				end
			end
			CELL_REMOVE: begin
				if (MY_IDX >= pos) begin
					data_next = right_data;
				end
			end
			CELL_ROTATE: data_next = right_data;
		endcase
	end

	// Payload register, no reset needed.
	always_ff @(posedge clk) begin
		data_q <= data_next;
	end

	assign data = data_q;

endmodule

[hdl/ole_ctrl.sv]
// Request decoder, element count, search sequencer and output register.
// Depends on ole_pkg; drives the row of ole_cell instances.
module ole_ctrl import ole_pkg::*; #(
	parameter int CAPACITY = DEFAULT_CAPACITY,
	parameter int AW       = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         op,
	input  logic [6:0]         position,
	input  logic [VALUE_W-1:0] item_value,
	input  logic [VALUE_W-1:0] head_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         out_status,
	output logic               out_found,
	output logic [5:0]         out_found_position,
	output logic [6:0]         out_count,
	output cell_cmd_t          cell_cmd,
	output logic [AW-1:0]      cell_pos
);

	localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [AW-1:0] CAP     = AW'(CAPACITY);
	localparam logic [SW-1:0] LAST_ST = SW'(CAPACITY - 1);

	fsm_state_t         state_q, state_next;
	logic [AW-1:0]      count_q;
	logic [VALUE_W-1:0] key_q;
	logic [SW-1:0]      step_q;
	logic               found_q;
	logic [5:0]         fpos_q;
	logic               out_valid_q;
	status_t            out_status_q;
	logic               out_found_q;
	logic [5:0]         out_fpos_q;
	logic [AW-1:0]      out_count_q;

	logic               accept;
	logic               search_last;
	logic               hit;
	op_code_t           op_code;
	logic [AW-1:0]      pos_ext;
	logic [AW-1:0]      req_pos;
	cell_op_t           req_kind;
	status_t            req_status;
	logic [AW-1:0]      req_count;

	assign op_code     = op_code_t'(op);
	assign pos_ext     = AW'(position);
	assign accept      = in_valid && in_ready;
	assign search_last = (state_q == FSM_SEARCH) && (step_q == LAST_ST);
	assign hit         = !found_q && (AW'(step_q) < count_q) && (head_data == key_q);

	// Decode one request against the current count.
	always_comb begin
		req_pos    = '0;
		req_kind   = CELL_HOLD;
		req_status = ST_DONE;
		req_count  = count_q;
		unique case (op_code)
			OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
				if (op_code == OP_INS_FRONT) begin
					req_pos = '0;
				end else if (op_code == OP_INS_BACK) begin
					req_pos = count_q;
				end else begin
					req_pos = pos_ext;
				end
				if (req_pos > count_q) begin
					req_status = ST_IGNORED;
				end else if (count_q >= CAP) begin
					req_status = ST_FULL;
				end else begin
					req_kind  = CELL_INSERT;
					req_count = count_q + AW'(1);
				end
			end
			OP_RM_FRONT, OP_RM_BACK, OP_RM_AT: begin
				if (op_code == OP_RM_FRONT) begin
					req_pos = '0;
				end else if (op_code == OP_RM_BACK) begin
					req_pos = count_q - AW'(1);
				end else begin
					req_pos = pos_ext;
				end
				if (count_q == '0 || req_pos >= count_q) begin
					req_status = ST_IGNORED;
				end else begin
					req_kind  = CELL_REMOVE;
					req_count = count_q - AW'(1);
				end
			end
			OP_SEARCH: req_kind = CELL_HOLD;
			OP_CLEAR:  req_count = '0;
		endcase
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (accept && op_code == OP_SEARCH) begin
					state_next = FSM_SEARCH;
				end
			end
			FSM_SEARCH: begin
				if (search_last) begin
					state_next = FSM_IDLE;
				end
			end
		endcase
	end

	// Outputs of the state machine: handshake and cell commands.
	always_comb begin
		in_ready       = 1'b0;
		cell_cmd.kind  = CELL_HOLD;
		cell_cmd.value = item_value;
		cell_pos       = req_pos;
		unique case (state_q)
			FSM_IDLE: begin
				in_ready = !out_valid_q || out_ready;
				if (accept) begin
					cell_cmd.kind = req_kind;
				end
			end
			FSM_SEARCH: cell_cmd.kind = CELL_ROTATE;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			step_q      <= '0;
			found_q     <= 1'b0;
		end else begin
			state_q <= state_next;
			if (accept) begin
				count_q <= req_count;
				step_q  <= '0;
				found_q <= 1'b0;
			end else if (state_q == FSM_SEARCH) begin
				step_q <= step_q + SW'(1);
				if (hit) begin
					found_q <= 1'b1;
				end
			end
			if ((accept && op_code != OP_SEARCH) || search_last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Search key, hit position and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= item_value;
			fpos_q <= '0;
		end else if (state_q == FSM_SEARCH && hit) begin
			fpos_q <= 6'(step_q);
		end
		if (accept && op_code != OP_SEARCH) begin
			out_status_q <= req_status;
			out_found_q  <= 1'b0;
			out_fpos_q   <= '0;
			out_count_q  <= req_count;
		end else if (search_last) begin
			out_status_q <= ST_DONE;
			out_found_q  <= found_q || hit;
			out_fpos_q   <= hit ? 6'(step_q) : fpos_q;
			out_count_q  <= count_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign out_status         = out_status_q;
	assign out_found          = out_found_q;
	assign out_found_position = out_fpos_q;
	assign out_count          = 7'(out_count_q);

endmodule

[hdl/ordered_list_engine_top.sv]
// Ordered list engine: a row of value cells plus the controller that drives them.
// Depends on ole_pkg, ole_cell and ole_ctrl.
//
// The list lives in a row of CAPACITY cells, element 0 in cell 0. For insert and
// remove requests every cell shifts in parallel, and clear only zeroes the count;
// for these the result is offered on the master side in the cycle after the item
// is accepted, so they sustain one item per cycle while the receiver keeps up. A
// search turns the row once around as a ring, each value passing the head
// comparator in turn, and the result follows the last step. A new item is taken
// only while the output register is empty or its result leaves in the same cycle,
// and never during a search. Insert positions beyond the count, remove positions
// at or beyond it and removals from an empty list report status ignored; inserts
// into a full list report status full.
module ordered_list_engine_top import ole_pkg::*; #(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // op[2:0], position[9:3], item_value[41:10], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // status[1:0], found[2], found_position[8:3], count[15:9]
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CW > 7) ? CW : 7;

	cell_cmd_t          cell_cmd;
	logic [AW-1:0]      cell_pos;
	logic [VALUE_W-1:0] cell_data [CAPACITY];
	logic [1:0]         status;
	logic               found;
	logic [5:0]         found_position;
	logic [6:0]         count;

	// Controller.
	ole_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW)
	) u_ctrl (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (s_tvalid),
		.in_ready           (s_tready),
		.op                 (s_tdata[2:0]),
		.position           (s_tdata[9:3]),
		.item_value         (s_tdata[41:10]),
		.head_data          (cell_data[0]),
		.out_valid          (m_tvalid),
		.out_ready          (m_tready),
		.out_status         (status),
		.out_found          (found),
		.out_found_position (found_position),
		.out_count          (count),
		.cell_cmd           (cell_cmd),
		.cell_pos           (cell_pos)
	);

	// Row of cells; the last one takes from cell 0 so the row closes into a ring.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ole_cell #(
			.AW  (AW),
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cell_cmd),
			.pos        (cell_pos),
			.left_data  ((i == 0) ? '0 : cell_data[(i == 0) ? 0 : i - 1]),
			.right_data (cell_data[(i == CAPACITY - 1) ? 0 : i + 1]),
			.data       (cell_data[i])
		);
	end

	assign m_tdata = {count, found_position, found, status};

endmodule

[hdl/ole_checker.sv]
// Port-level checker for the ordered list engine, bound to the top level.
// Depends on ole_pkg for the status codes and on ordered_list_engine_top's port list.
module ole_checker import ole_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// No new item is taken while the result register is full and stalled.
	a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("item accepted with no room for its result");

	// Status codes stay within their meaning.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3)
		else $error("undefined status code");

	// A search hit always reports done.
	a_found_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[1:0] == ST_DONE)
		else $error("found flag with non-done status");

	// Without a hit the position reads zero.
	a_miss_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[2] |-> m_tdata[8:3] == 6'd0)
		else $error("position nonzero without a hit");

endmodule

bind ordered_list_engine_top ole_checker u_ole_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[sim/ole_list_checker.sv]
// Checker for the ordered list engine: watches both stream channels, predicts every result
// from its own copy of the list and compares it with what the block returns.
// Depends on ole_pkg.
module ole_list_checker import ole_pkg::*; #(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,   // op[2:0], position[9:3], item_value[41:10], zero pad
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // status[1:0], found[2], found_position[8:3], count[15:9]
	output int          errors,
	output int          pending,
	output int          list_count
);

	// One result item, field by field.
	typedef struct packed {
		status_t     status;
		logic        found;
		logic [5:0]  found_position;
		logic [6:0]  count;
	} list_result_t;

	// Shadow copy of the list; entries at or above fill are never read.
	logic [VALUE_W-1:0] cells [CAPACITY];
	int                 fill;

	list_result_t expected_results [$];
	int           mismatch_count;

	// Insert one value at an index, shifting the tail up by one.
	function automatic status_t list_insert(int pos, logic [VALUE_W-1:0] val);
		if (pos > fill) begin
			return ST_IGNORED;
		end
		if (fill >= CAPACITY) begin
			return ST_FULL;
		end
		for (int i = fill; i > pos; i--) begin
			cells[i] = cells[i - 1];
		end
		cells[pos] = val;
		fill++;
		return ST_DONE;
	endfunction

	// Remove the value at an index, shifting the tail down by one.
	function automatic status_t list_remove(int pos);
		if (fill == 0 || pos >= fill) begin
			return ST_IGNORED;
		end
		for (int i = pos; i + 1 < fill; i++) begin
			cells[i] = cells[i + 1];
		end
		fill--;
		return ST_DONE;
	endfunction

	// Apply one request to the shadow list and return the result it should give.
	function automatic list_result_t list_apply(op_code_t op, int pos, logic [VALUE_W-1:0] val);
		list_result_t res;
		res = '0;
		res.status = ST_DONE;
		case (op)
			OP_INS_FRONT: res.status = list_insert(0, val);
			OP_INS_BACK:  res.status = list_insert(fill, val);
			OP_INS_AT:    res.status = list_insert(pos, val);
			OP_RM_FRONT:  res.status = list_remove(0);
			OP_RM_BACK:   res.status = (fill == 0) ? ST_IGNORED : list_remove(fill - 1);
			OP_RM_AT:     res.status = list_remove(pos);
			OP_SEARCH: begin
				for (int i = 0; i < fill; i++) begin
					if (cells[i] == val) begin
						res.found          = 1'b1;
						res.found_position = 6'(i);
						break;
					end
				end
			end
			default:      fill = 0;
		endcase
		res.count = 7'(fill);
		return res;
	endfunction

	// Compare returned items first, then record the item accepted at this edge.
	always @(posedge clk) begin
		list_result_t got;
		list_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.status         = status_t'(m_tdata[1:0]);
				got.found          = m_tdata[2];
				got.found_position = m_tdata[8:3];
				got.count          = m_tdata[15:9];
				if (expected_results.size() == 0) begin
					if (mismatch_count < 10) begin
						$display("unexpected result: status %0d found %0d pos %0d count %0d",
							got.status, got.found, got.found_position, got.count);
					end
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						if (mismatch_count < 10) begin
							$display("mismatch: expected status %0d found %0d pos %0d count %0d, got status %0d found %0d pos %0d count %0d",
								want.status, want.found, want.found_position, want.count,
								got.status, got.found, got.found_position, got.count);
						end
						mismatch_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				expected_results.push_back(list_apply(op_code_t'(s_tdata[2:0]),
					int'(s_tdata[9:3]), s_tdata[41:10]));
			end
			errors     <= mismatch_count;
			pending    <= expected_results.size();
			list_count <= fill;
		end
	end

endmodule

[sim/tb_ordered_list_engine_top.sv]
// Testbench top for the ordered list engine: clock, reset, request stimulus and the
// receiver's stall pattern, with the verdict taken from the checker's failure count.
// Depends on ole_pkg, ordered_list_engine_top and ole_list_checker.
module tb_ordered_list_engine_top;
	import ole_pkg::*;

	localparam int CAP          = DEFAULT_CAPACITY;
	localparam int RANDOM_ITEMS = 1200;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_START   = 2000;
	localparam int HOLD_CYCLES  = 600;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // op[2:0], position[9:3], item_value[41:10], zero pad
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // status[1:0], found[2], found_position[8:3], count[15:9]

	int errors;
	int pending;
	int list_count;
	int cycle_count;

	// Values that requests draw from, so that searches hit stored entries.
	logic [VALUE_W-1:0] value_pool [16];

	ordered_list_engine_top #(.CAPACITY(CAP)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	ole_list_checker #(.CAPACITY(CAP)) CHK (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.errors     (errors),
		.pending    (pending),
		.list_count (list_count)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// Pack one request item.
	function automatic logic [47:0] make_item(op_code_t op, logic [6:0] pos,
		logic [VALUE_W-1:0] val);
		return {6'b0, val, pos, op};
	endfunction

	// Offer one item and hold it until the block takes it.
	task automatic send_item(input logic [47:0] item);
		s_tdata  <= item;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// Receiver: changing stall styles, with one long hold-off while requests keep coming.
	initial begin
		int rx_cycles;
		int hold_left;
		int style;
		int span;
		rx_cycles = 0;
		hold_left = 0;
		style     = 0;
		span      = 0;
		m_tready <= 1'b0;
		repeat (4) @(posedge clk);
		forever begin
			@(posedge clk);
			rx_cycles++;
			if (rx_cycles == HOLD_START) begin
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (span == 0) begin
					style = $urandom_range(0, 3);
					span  = $urandom_range(20, 200);
				end
				span--;
				case (style)
					0:       m_tready <= 1'b1;
					1:       m_tready <= ($urandom_range(0, 3) != 0);
					2:       m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ~m_tready;
				endcase
			end
		end
	end

	// Stimulus: reset, directed requests, then random requests in bursts.
	initial begin
		int                 burst_left;
		int                 gap;
		int                 mode;
		int                 mode_left;
		int                 r;
		int                 p_ins;
		int                 p_rm;
		int                 p_search;
		op_code_t           op;
		logic [6:0]         pos;
		logic [VALUE_W-1:0] val;

		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		for (int k = 0; k < 16; k++) begin
			value_pool[k] = $urandom();
		end
		value_pool[0] = 32'h0000_0000;
		value_pool[1] = 32'hFFFF_FFFF;
		value_pool[2] = 32'h7FFF_FFFF;
		value_pool[3] = 32'h8000_0000;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list: search miss, removals ignored, insert-at past the end ignored.
		send_item(make_item(OP_SEARCH,    7'd0,   32'h0000_0000));
		send_item(make_item(OP_RM_FRONT,  7'd0,   32'h0000_0000));
		send_item(make_item(OP_RM_BACK,   7'd0,   32'h0000_0000));
		send_item(make_item(OP_RM_AT,     7'd0,   32'h0000_0000));
		send_item(make_item(OP_INS_AT,    7'd1,   32'h1234_5678));
		// Build a short list with extreme values; position is ignored by front and back.
		send_item(make_item(OP_INS_FRONT, 7'h7F,  32'h7FFF_FFFF));
		send_item(make_item(OP_INS_BACK,  7'h40,  32'h8000_0000));
		send_item(make_item(OP_INS_AT,    7'd1,   32'h0000_0000));
		send_item(make_item(OP_INS_AT,    7'd3,   32'hFFFF_FFFF));
		send_item(make_item(OP_INS_AT,    7'd64,  32'h0000_0005));
		send_item(make_item(OP_INS_BACK,  7'd0,   32'h0000_0000));
		// Searches: hit, first of two matches, and a miss.
		send_item(make_item(OP_SEARCH,    7'h7F,  32'h8000_0000));
		send_item(make_item(OP_SEARCH,    7'd0,   32'h0000_0000));
		send_item(make_item(OP_SEARCH,    7'h7F,  32'h0000_3039));
		// Removals: the last index, then the same index once it is out of range.
		send_item(make_item(OP_RM_AT,     7'd4,   32'hFFFF_FFFF));
		send_item(make_item(OP_RM_AT,     7'd4,   32'h0000_0000));
		send_item(make_item(OP_RM_AT,     7'd1,   32'h0000_0000));
		send_item(make_item(OP_RM_BACK,   7'h7F,  32'h0000_0000));
		send_item(make_item(OP_RM_FRONT,  7'h7F,  32'hFFFF_FFFF));
		// Clear a non-empty list, then an empty one, then search stale contents.
		send_item(make_item(OP_INS_BACK,  7'd0,   32'hFFFF_FFFF));
		send_item(make_item(OP_CLEAR,     7'h7F,  32'hFFFF_FFFF));
		send_item(make_item(OP_CLEAR,     7'd0,   32'h0000_0000));
		send_item(make_item(OP_SEARCH,    7'd0,   32'hFFFF_FFFF));

		// Random part: phases that grow, shrink or mix the list, plus some noise.
		burst_left = $urandom_range(1, 24);
		mode_left  = 0;
		mode       = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 2);
				mode_left = $urandom_range(80, 200);
			end
			mode_left--;
			case (mode)
				0: begin
					p_ins = 75; p_rm = 8;  p_search = 17;
				end
				1: begin
					p_ins = 15; p_rm = 65; p_search = 18;
				end
				default: begin
					p_ins = 40; p_rm = 35; p_search = 23;
				end
			endcase

			r = $urandom_range(0, 99);
			if (r < p_ins) begin
				case ($urandom_range(0, 2))
					0:       op = OP_INS_FRONT;
					1:       op = OP_INS_BACK;
					default: op = OP_INS_AT;
				endcase
			end else if (r < p_ins + p_rm) begin
				case ($urandom_range(0, 2))
					0:       op = OP_RM_FRONT;
					1:       op = OP_RM_BACK;
					default: op = OP_RM_AT;
				endcase
			end else if (r < p_ins + p_rm + p_search) begin
				op = OP_SEARCH;
			end else begin
				op = OP_CLEAR;
			end
			pos = 7'($urandom_range(0, list_count + 1));
			val = ($urandom_range(0, 2) == 0) ? $urandom() : value_pool[$urandom_range(0, 15)];

			// Now and then a request with every field random.
			if ($urandom_range(0, 9) == 0) begin
				op  = op_code_t'(3'($urandom()));
				pos = 7'($urandom());
				val = $urandom();
			end

			send_item(make_item(op, pos, val));

			burst_left--;
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 24);
			end
		end
		s_tvalid <= 1'b0;

		// Drain: wait for every result, then give a late extra result time to show up.
		do @(posedge clk); while (pending != 0);
		repeat (CAP + 16) @(posedge clk);

		if (errors == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

[sim.f]
hdl/ole_pkg.sv
hdl/ole_cell.sv
hdl/ole_ctrl.sv
hdl/ordered_list_engine_top.sv
hdl/ole_checker.sv
sim/ole_list_checker.sv
sim/tb_ordered_list_engine_top.sv
